// File: rtl/pdrq_pkg.sv
package pdrq_pkg;

	localparam int unsigned PID_W  = 16;
	localparam int unsigned FILE_W = 16;
	localparam int unsigned FUNC_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_REQUEST   = 2'd0,
		FN_COMPLETE  = 2'd1,
		FN_TERMINATE = 2'd2,
		FN_RESERVED  = 2'd3
	} func_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [FILE_W-1:0] file;
	} entry_t;

endpackage

// File: rtl/per_disk_request_queues.sv
// per_disk_request_queues: service slot and fcfs wait queue for each disk
// request, complete and plain terminate pass through the read, execute and output states after accept
// one item at a time: in_stall is high from accept until the result is taken (read, execute, output, handshake)
// terminate with a purge walks the queue, then updates the count, before the output state
// reset (arst_n low, asynchronous): slots idle, heads and counts zero, disks_in_use 8
// queue memory is not cleared; only entries within the count are ever used
module per_disk_request_queues #(
	parameter int unsigned MAX_DISKS   = 8,
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  disk_index,
	input  logic [15:0] pid,
	input  logic [15:0] file_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] completed_pid,
	output logic [15:0] serving_pid,
	output logic [15:0] serving_file,
	output logic [4:0]  waiting_count,
	output logic        accepted,
	output logic        overflow
);

	localparam int unsigned DW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
	localparam int unsigned QW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned AW = DW + QW;
	// one power-of-two region per disk, addressed as {disk, position}
	localparam int unsigned QDEP = 2 ** AW;

	// control sequencer
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_PURGE = 6'b001000,
		ST_PDRN  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// per-disk slot and queue state: one slot entry per disk, queue memory in one region per disk
	pdrq_pkg::entry_t slot_mem [MAX_DISKS];
	pdrq_pkg::entry_t queue_mem [QDEP];
	logic [QW-1:0] head_q [MAX_DISKS];
	logic [CW-1:0] count_q [MAX_DISKS];
	logic [MAX_DISKS-1:0] slot_vld_q;

	logic [3:0] disks_q;

	// latched item
	logic [1:0]  func_q;
	logic [DW-1:0] disk_q;
	logic [15:0] pid_q;
	logic [15:0] tag_q;
	logic        dvalid_q;

	// memory read ports
	pdrq_pkg::entry_t slot_rd_q;
	pdrq_pkg::entry_t q_rd_q;
	logic [AW-1:0] q_raddr;
	logic          q_re;
	logic [AW-1:0] q_waddr;
	logic          q_we;
	pdrq_pkg::entry_t q_wdata;

	// purge walk
	logic [CW-1:0] walk_q;
	logic [QW-1:0] rd_pos_q;
	logic [QW-1:0] wr_pos_q;
	logic [CW-1:0] kept_q;
	logic          rd_pend_q;

	logic acc_in;
	logic [QW-1:0] head_d;
	logic [CW-1:0] cnt_d;
	pdrq_pkg::entry_t slot_cur;

	assign in_stall = (state_q != ST_IDLE);
	assign acc_in   = in_valid && !in_stall;
	assign head_d   = head_q[disk_q];
	assign cnt_d    = count_q[disk_q];
	assign slot_cur = slot_vld_q[disk_q] ? slot_rd_q : '0;

	function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] a,
		input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
		return s[QW-1:0];
	endfunction

	// queue memory read address: head for advance, walk pointer for purge
	always_comb begin
		q_re    = 1'b0;
		q_raddr = {disk_q, head_d};
		if (state_q == ST_READ) begin
			q_re = 1'b1;
		end else if (state_q == ST_PURGE && walk_q != '0) begin
			q_re    = 1'b1;
			q_raddr = {disk_q, rd_pos_q};
		end
	end

	always_ff @(posedge clk) begin
		if (q_re) q_rd_q <= queue_mem[q_raddr];
		if (q_we) queue_mem[q_waddr] <= q_wdata;
		if (state_q == ST_IDLE) slot_rd_q <= slot_mem[disk_index[DW-1:0]];
	end

	// queue write: append on request, compaction during purge
	always_comb begin
		q_we    = 1'b0;
		q_waddr = {disk_q, wrap_add(head_d, cnt_d)};
		q_wdata = '{pid: pid_q, file: tag_q};
		if (state_q == ST_EXEC && dvalid_q && func_q == pdrq_pkg::FN_REQUEST
			&& pid_q > 16'd1 && slot_cur.pid != '0
			&& cnt_d < CW'(QUEUE_DEPTH)) begin
			q_we = 1'b1;
		end else if (rd_pend_q && q_rd_q.pid != pid_q) begin
			q_we    = 1'b1;
			q_waddr = {disk_q, wr_pos_q};
			q_wdata = q_rd_q;
		end
	end

	logic slot_we;
	pdrq_pkg::entry_t slot_wd;
	logic adv;
	logic res_acc, res_ovf;
	logic [15:0] res_comp;

	always_comb begin
		adv = 1'b0;
		slot_we = 1'b0;
		slot_wd = slot_cur;
		res_acc = 1'b0;
		res_ovf = 1'b0;
		res_comp = '0;
		case (func_q)
			pdrq_pkg::FN_REQUEST: begin
				if (pid_q > 16'd1) begin
					if (slot_cur.pid == '0) begin
						slot_we = 1'b1;
						slot_wd = '{pid: pid_q, file: tag_q};
						res_acc = 1'b1;
					end else if (cnt_d < CW'(QUEUE_DEPTH)) begin
						res_acc = 1'b1;
					end else begin
						res_ovf = 1'b1;
					end
				end
			end
			pdrq_pkg::FN_COMPLETE: begin
				res_comp = slot_cur.pid;
				adv = 1'b1;
				res_acc = 1'b1;
			end
			pdrq_pkg::FN_TERMINATE: begin
				adv = (slot_cur.pid == pid_q);
				res_acc = 1'b1;
			end
			default: ;
		endcase
		if (adv) begin
			slot_we = 1'b1;
			slot_wd = (cnt_d != '0) ? q_rd_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && dvalid_q && slot_we) slot_mem[disk_q] <= slot_wd;
		if (state_q == ST_EXEC) begin
			// an out-of-range disk shows an empty slot
			serving_pid  <= dvalid_q ? slot_wd.pid : '0;
			serving_file <= dvalid_q ? slot_wd.file : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			disks_q    <= 4'd8;
			slot_vld_q <= '0;
			out_valid  <= 1'b0;
			rd_pend_q  <= 1'b0;
			for (int i = 0; i < MAX_DISKS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) disks_q <= cfg_wdata;
			rd_pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						func_q   <= func;
						disk_q   <= disk_index[DW-1:0];
						pid_q    <= pid;
						tag_q    <= file_tag;
						dvalid_q <= (disk_index < disks_q) &&
							({1'b0, disk_index} < 5'(MAX_DISKS));
						state_q  <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					completed_pid <= res_comp;
					accepted      <= dvalid_q && res_acc;
					overflow      <= dvalid_q && res_ovf;
					waiting_count <= 5'(cnt_d);
					state_q       <= ST_OUT;
					if (!dvalid_q) begin
						completed_pid <= '0;
						waiting_count <= '0;
					end else begin
						if (slot_we) slot_vld_q[disk_q] <= 1'b1;
						if (q_we) begin
							count_q[disk_q] <= cnt_d + 1'b1;
							waiting_count   <= 5'(cnt_d + 1'b1);
						end
						if (adv && cnt_d != '0) begin
							head_q[disk_q]  <= wrap_add(head_d, CW'(1));
							count_q[disk_q] <= cnt_d - 1'b1;
							waiting_count   <= 5'(cnt_d - 1'b1);
						end
						if (func_q == pdrq_pkg::FN_TERMINATE && !adv) begin
							walk_q   <= cnt_d;
							rd_pos_q <= head_d;
							wr_pos_q <= head_d;
							kept_q   <= '0;
							state_q  <= ST_PURGE;
						end
					end
				end
				ST_PURGE: begin
					// one read per cycle, the write of a kept entry in the next cycle
					if (rd_pend_q && q_rd_q.pid != pid_q) begin
						wr_pos_q <= wrap_add(wr_pos_q, CW'(1));
						kept_q   <= kept_q + 1'b1;
					end
					if (walk_q != '0) begin
						walk_q    <= walk_q - 1'b1;
						rd_pos_q  <= wrap_add(rd_pos_q, CW'(1));
						rd_pend_q <= 1'b1;
					end else begin
						state_q <= ST_PDRN;
					end
				end
				ST_PDRN: begin
					count_q[disk_q] <= kept_q;
					waiting_count   <= 5'(kept_q);
					state_q         <= ST_OUT;
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// only one item in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		overflow && out_valid |-> !accepted)
		else $error("overflow and accepted together");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PURGE |-> kept_q <= CW'(QUEUE_DEPTH))
		else $error("purge kept more than depth");

endmodule

// File: tb/sv/tb.sv
module tb;

	localparam int unsigned N_DISKS = 8;
	localparam int unsigned Q_DEPTH = 16;
	localparam int unsigned N_RANDOM = 1030;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  fn;
		logic [3:0]  disk;
		logic [15:0] proc;
		logic [15:0] tag;
	} op_t;

	typedef struct packed {
		logic [15:0] done_pid;
		logic [15:0] srv_pid;
		logic [15:0] srv_file;
		logic [4:0]  waiting;
		logic        acc;
		logic        ovf;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = 2'd0;
	logic [3:0]  disk_index = 4'd0;
	logic [15:0] pid = 16'd0;
	logic [15:0] file_tag = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] completed_pid;
	logic [15:0] serving_pid;
	logic [15:0] serving_file;
	logic [4:0]  waiting_count;
	logic        accepted;
	logic        overflow;

	// model state of the block
	logic [3:0]  m_disks;
	logic [15:0] m_slot_pid [N_DISKS];
	logic [15:0] m_slot_file [N_DISKS];
	logic [15:0] m_q_pid [N_DISKS][Q_DEPTH];
	logic [15:0] m_q_file [N_DISKS][Q_DEPTH];
	int unsigned m_head [N_DISKS];
	int unsigned m_count [N_DISKS];

	op_t     pending_ops[$];
	status_t expected_status[$];
	int      errors = 0;
	longint  cycle = 0;
	bit      quiet_phase = 1'b0;   // no idling on either side
	int      hold_cycles = 0;      // receiver hold-off requested by stimulus

	per_disk_request_queues i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .disk_index(disk_index), .pid(pid), .file_tag(file_tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.completed_pid(completed_pid), .serving_pid(serving_pid),
		.serving_file(serving_file), .waiting_count(waiting_count),
		.accepted(accepted), .overflow(overflow)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// move the head of a disk's queue into its service slot
	function automatic void slot_advance(int unsigned d);
		if (m_count[d] != 0) begin
			m_slot_pid[d] = m_q_pid[d][m_head[d]];
			m_slot_file[d] = m_q_file[d][m_head[d]];
			m_head[d] = (m_head[d] + 1) % Q_DEPTH;
			m_count[d]--;
		end else begin
			m_slot_pid[d] = '0;
			m_slot_file[d] = '0;
		end
	endfunction

	// work out the status that one operation yields, updating the model
	function automatic status_t disk_op_status(op_t op);
		status_t s;
		int unsigned d, rd, wr, kept, pos;
		s = '0;
		d = op.disk;
		if (op.disk >= m_disks || op.disk >= N_DISKS)
			return s;
		case (op.fn)
			pdrq_pkg::FN_REQUEST: begin
				if (op.proc > 1) begin
					if (m_slot_pid[d] == 0) begin
						m_slot_pid[d] = op.proc;
						m_slot_file[d] = op.tag;
						s.acc = 1'b1;
					end else if (m_count[d] < Q_DEPTH) begin
						pos = (m_head[d] + m_count[d]) % Q_DEPTH;
						m_q_pid[d][pos] = op.proc;
						m_q_file[d][pos] = op.tag;
						m_count[d]++;
						s.acc = 1'b1;
					end else begin
						s.ovf = 1'b1;
					end
				end
			end
			pdrq_pkg::FN_COMPLETE: begin
				s.done_pid = m_slot_pid[d];
				slot_advance(d);
				s.acc = 1'b1;
			end
			pdrq_pkg::FN_TERMINATE: begin
				if (m_slot_pid[d] == op.proc) begin
					slot_advance(d);
				end else begin
					// compact the queue, keeping the order of the survivors
					rd = m_head[d];
					wr = m_head[d];
					kept = 0;
					for (int unsigned i = 0; i < m_count[d]; i++) begin
						if (m_q_pid[d][rd] != op.proc) begin
							m_q_pid[d][wr] = m_q_pid[d][rd];
							m_q_file[d][wr] = m_q_file[d][rd];
							wr = (wr + 1) % Q_DEPTH;
							kept++;
						end
						rd = (rd + 1) % Q_DEPTH;
					end
					m_count[d] = kept;
				end
				s.acc = 1'b1;
			end
			default: ;
		endcase
		s.srv_pid = m_slot_pid[d];
		s.srv_file = m_slot_file[d];
		s.waiting = 5'(m_count[d]);
		return s;
	endfunction

	// driver: offers queued items, idling now and then
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (pending_ops.size() != 0 && (quiet_phase || $urandom_range(99) >= 17)) begin
				op_t op;
				status_t st;
				op = pending_ops.pop_front();
				st = disk_op_status(op);
				expected_status = {expected_status, st};
				in_valid <= 1'b1;
				func <= op.fn;
				disk_index <= op.disk;
				pid <= op.proc;
				file_tag <= op.tag;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall: random, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= !quiet_phase && ($urandom_range(99) < 17);
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result pid %0d", $realtime, serving_pid);
				errors++;
			end else begin
				status_t e;
				e = expected_status.pop_front();
				if (completed_pid !== e.done_pid) begin
					$display("%0t: completed_pid expected %0d actual %0d",
						$realtime, e.done_pid, completed_pid);
					errors++;
				end
				if (serving_pid !== e.srv_pid) begin
					$display("%0t: serving_pid expected %0d actual %0d",
						$realtime, e.srv_pid, serving_pid);
					errors++;
				end
				if (serving_file !== e.srv_file) begin
					$display("%0t: serving_file expected %0d actual %0d",
						$realtime, e.srv_file, serving_file);
					errors++;
				end
				if (waiting_count !== e.waiting) begin
					$display("%0t: waiting_count expected %0d actual %0d",
						$realtime, e.waiting, waiting_count);
					errors++;
				end
				if (accepted !== e.acc) begin
					$display("%0t: accepted expected %0b actual %0b",
						$realtime, e.acc, accepted);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$display("%0t: overflow expected %0b actual %0b",
						$realtime, e.ovf, overflow);
					errors++;
				end
			end
		end
	end

	function automatic op_t make_op(logic [1:0] fn, logic [3:0] disk,
			logic [15:0] proc, logic [15:0] tag);
		op_t op;
		op.fn = fn;
		op.disk = disk;
		op.proc = proc;
		op.tag = tag;
		return op;
	endfunction

	// append one item to the pending list
	function automatic void add_op(op_t op);
		pending_ops = {pending_ops, op};
	endfunction

	// random item, mostly on valid disks with pids from a small pool
	function automatic op_t random_op(int unsigned disk_span);
		op_t op;
		int unsigned r;
		r = $urandom_range(99);
		op.fn = (r < 50) ? pdrq_pkg::FN_REQUEST : (r < 78) ? pdrq_pkg::FN_COMPLETE :
			(r < 96) ? pdrq_pkg::FN_TERMINATE : pdrq_pkg::FN_RESERVED;
		op.disk = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
			: 4'($urandom_range(disk_span - 1));
		r = $urandom_range(9);
		op.proc = (r == 0) ? 16'($urandom_range(1)) : (r == 1) ? 16'($urandom)
			: 16'($urandom_range(9, 2));
		if ($urandom_range(49) == 0)
			op.proc = 16'hffff;
		op.tag = 16'($urandom);
		return op;
	endfunction

	task automatic drain_all();
		while (pending_ops.size() != 0 || expected_status.size() != 0)
			@(posedge clk);
		// extra idle time after the last result
		repeat (50) @(posedge clk);
	endtask

	task automatic write_disks(logic [3:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_disks = value;
	endtask

	initial begin
		logic [3:0] settings [4];
		m_disks = 4'd8;
		for (int d = 0; d < N_DISKS; d++) begin
			m_slot_pid[d] = '0;
			m_slot_file[d] = '0;
			m_head[d] = 0;
			m_count[d] = 0;
			for (int q = 0; q < Q_DEPTH; q++) begin
				m_q_pid[d][q] = '0;
				m_q_file[d][q] = '0;
			end
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: low pids, bad disks, idle complete, full queue, purges
		add_op(make_op(pdrq_pkg::FN_COMPLETE, 4'd0, 16'd0, 16'd0));
		add_op(make_op(pdrq_pkg::FN_REQUEST, 4'd0, 16'd0, 16'hffff));
		add_op(make_op(pdrq_pkg::FN_REQUEST, 4'd0, 16'd1, 16'h1234));
		add_op(make_op(pdrq_pkg::FN_REQUEST, 4'd15, 16'hffff, 16'hffff));
		add_op(make_op(pdrq_pkg::FN_REQUEST, 4'd8, 16'd5, 16'd5));
		add_op(make_op(pdrq_pkg::FN_RESERVED, 4'd0, 16'd5, 16'd5));
		add_op(make_op(pdrq_pkg::FN_REQUEST, 4'd7, 16'hffff, 16'hffff));
		for (int i = 0; i < 17; i++)
			add_op(make_op(pdrq_pkg::FN_REQUEST, 4'd0, 16'(2 + i % 3),
				16'($urandom)));
		add_op(make_op(pdrq_pkg::FN_TERMINATE, 4'd0, 16'd3, 16'd0));
		add_op(make_op(pdrq_pkg::FN_TERMINATE, 4'd0, 16'd2, 16'd0));
		add_op(make_op(pdrq_pkg::FN_TERMINATE, 4'd0, 16'd99, 16'd0));
		add_op(make_op(pdrq_pkg::FN_COMPLETE, 4'd0, 16'd0, 16'd0));
		add_op(make_op(pdrq_pkg::FN_TERMINATE, 4'd7, 16'hffff, 16'hffff));
		drain_all();

		// random phases over several disk counts, the extremes among them
		settings = '{4'd1, 4'd15, 4'd3, 4'd0};
		for (int p = 0; p < 4; p++) begin
			write_disks(settings[p]);
			quiet_phase = (p == 1);
			for (int i = 0; i < N_RANDOM / 4; i++)
				add_op(random_op((settings[p] == 0) ? 8
					: (settings[p] > 8 ? 8 : settings[p])));
			if (p == 2) begin
				// long hold-off while the sender keeps offering items
				hold_cycles = 300;
			end
			drain_all();
		end
		write_disks(4'd8);
		quiet_phase = 1'b0;
		for (int i = 0; i < 20; i++)
			add_op(random_op(8));
		drain_all();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: per_disk_request_queues.f
rtl/pdrq_pkg.sv
rtl/per_disk_request_queues.sv
tb/sv/tb.sv
